>>> rtl/cht_pkg.sv
package cht_pkg;
	localparam int BUCKETS = 32;
	localparam int NODES = 64;
	localparam int DEFAULT_BUCKETS = 4;
	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(NODES);
	localparam int LW = NW + 1;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CFG_W = 6;
	localparam int NODE_W = KEY_W + VAL_W + LW;

	typedef logic [LW-1:0] link_t;

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EXISTS    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam link_t NULL_LINK = link_t'(NODES);
endpackage

>>> rtl/chained_hash_table_top.sv
// A request passes through the bucket hash, the head read, a check per chain node visited
// (an empty chain still has one check), an insert or delete step where needed and a finish step; the strobe follows.
// Throughput: one request at a time; busy falls as the result strobe rises.
// The hash is a bit-serial divider, the walk is one node memory read per node.
// After reset an init pass fills the free list, clearing the bucket heads in its first part
// as well; busy is high meanwhile. The receiver cannot stall.
module chained_hash_table_top
	import cht_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       op,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	output logic             done,
	output logic [1:0]       status,
	output logic [VAL_W-1:0] found_value,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_HASH, S_HEAD, S_RDN, S_NODE, S_CHK, S_INS, S_DEL, S_DONE
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] bcnt_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [BW-1:0]    bkt_q;
	link_t            cur_q, prev_q;
	logic [NW:0]      steps_q, fcnt_q;
	logic [NW:0]      init_q;
	logic [1:0]       st_q;
	logic [VAL_W-1:0] fv_q;
	logic             fs_pend_q;

	logic [BW:0] divisor;
	logic        mod_go, mod_done;
	logic [BW-1:0] mod_rem;

	always_comb begin
		if (bcnt_q == '0) begin
			divisor = (BW+1)'(DEFAULT_BUCKETS < BUCKETS ? DEFAULT_BUCKETS : BUCKETS);
		end else if (32'(bcnt_q) > BUCKETS) begin
			divisor = (BW+1)'(BUCKETS);
		end else begin
			divisor = (BW+1)'(bcnt_q);
		end
	end

	assign mod_go = (state_q == S_IDLE) && start;

	cht_mod u_mod (
		.clk(clk), .arst_n(arst_n), .go(mod_go), .key(key),
		.divisor(divisor), .done(mod_done), .rem(mod_rem)
	);

	logic          hd_we;
	logic [BW-1:0] hd_wa, hd_ra;
	link_t         hd_wd, hd_rd;
	logic              nd_we;
	logic [NW-1:0]     nd_wa, nd_ra;
	logic [NODE_W-1:0] nd_wd, nd_rd;
	logic          fs_we;
	logic [NW-1:0] fs_wa, fs_ra, fs_wd, fs_rd;

	cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	cht_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd));
	cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

	logic [KEY_W-1:0] nd_key;
	logic [VAL_W-1:0] nd_val;
	link_t            nd_next;
	assign {nd_key, nd_val, nd_next} = nd_rd;

	logic hit, at_end;
	assign at_end = cur_q[NW] || steps_q == (NW+1)'(NODES);
	assign hit = !at_end && nd_key == key_q;

	// memory writes: insert writes new node and head; delete relinks prev (key/value rewritten) or the head
	logic [NODE_W-1:0] pv_q;
	always_comb begin
		hd_we = 1'b0; hd_wa = bkt_q; hd_wd = NULL_LINK; hd_ra = bkt_q;
		nd_we = 1'b0; nd_wa = fs_rd; nd_wd = {key_q, val_q, hd_rd};
		nd_ra = cur_q[NW-1:0];
		fs_we = 1'b0; fs_wa = fcnt_q[NW-1:0]; fs_wd = cur_q[NW-1:0];
		fs_ra = NW'(fcnt_q - 1'b1);
		case (state_q)
			S_INIT: begin
				if (init_q < (NW+1)'(BUCKETS)) begin
					hd_we = 1'b1;
					hd_wa = init_q[BW-1:0];
				end
				fs_we = 1'b1;
				fs_wa = init_q[NW-1:0];
				fs_wd = NW'((NODES - 1) - 32'(init_q[NW-1:0]));
			end
			S_INS: begin
				nd_we = 1'b1;
				hd_we = 1'b1;
				hd_wd = {1'b0, fs_rd};
			end
			S_DEL: begin
				if (prev_q[NW]) begin
					hd_we = 1'b1;
					hd_wd = nd_next;
				end else begin
					nd_we = 1'b1;
					nd_wa = prev_q[NW-1:0];
					nd_wd = {pv_q[NODE_W-1:LW], nd_next};
				end
				fs_we = fs_pend_q;
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign status = st_q;
	assign found_value = fv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			bcnt_q <= CFG_W'(DEFAULT_BUCKETS);
			init_q <= '0;
			fcnt_q <= (NW+1)'(NODES);
			done <= 1'b0;
			st_q <= ST_NOT_FOUND;
			fv_q <= '0;
			cur_q <= NULL_LINK;
			prev_q <= NULL_LINK;
			steps_q <= '0;
			fs_pend_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				bcnt_q <= cfg_data;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (NW+1)'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_RDN;
				end
				S_RDN: begin
					cur_q <= hd_rd;
					prev_q <= NULL_LINK;
					steps_q <= '0;
					state_q <= S_NODE;
				end
				S_NODE: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cur_q[NW] || steps_q == (NW+1)'(NODES)) begin
						st_q <= ST_NOT_FOUND;
						fv_q <= '0;
						state_q <= S_DONE;
						if (op_q == OP_INSERT) begin
							if (fcnt_q == '0) begin
								st_q <= ST_FULL;
							end else begin
								st_q <= ST_OK;
								fcnt_q <= fcnt_q - 1'b1;
								state_q <= S_INS;
							end
						end
					end else if (hit) begin
						fv_q <= '0;
						state_q <= S_DONE;
						case (op_q)
							OP_FIND: begin
								st_q <= ST_OK;
								fv_q <= nd_val;
							end
							OP_INSERT: st_q <= ST_EXISTS;
							OP_DELETE: begin
								st_q <= ST_OK;
								fs_pend_q <= fcnt_q < (NW+1)'(NODES);
								state_q <= S_DEL;
							end
							default: st_q <= ST_NOT_FOUND;
						endcase
					end else begin
						prev_q <= cur_q;
						cur_q <= nd_next;
						steps_q <= steps_q + 1'b1;
						state_q <= S_NODE;
					end
				end
				S_INS: state_q <= S_DONE;
				S_DEL: begin
					if (fs_pend_q) begin
						fcnt_q <= fcnt_q + 1'b1;
					end
					fs_pend_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mod_go) begin
			op_q <= op;
			key_q <= key;
			val_q <= value;
		end
		if (mod_done) begin
			bkt_q <= mod_rem;
		end
		if (state_q == S_CHK && !at_end && !hit) begin
			pv_q <= nd_rd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy);
	assert property (@(posedge clk) disable iff (!arst_n) fcnt_q <= (NW+1)'(NODES));
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> fcnt_q < (NW+1)'(NODES));
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEL |-> !prev_q[NW] || hd_we);
endmodule

>>> rtl/cht_ram.sv
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/cht_mod.sv
module cht_mod
	import cht_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [KEY_W-1:0] key,
	input  logic [BW:0]      divisor,
	output logic             done,
	output logic [BW-1:0]    rem
);
	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] quo_q;
	logic [BW:0]      rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [BW+1:0]    trial;

	assign trial = {rem_q, quo_q[KEY_W-1]};
	assign rem = rem_q[BW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(KEY_W - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= key;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= (BW+1)'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[BW:0];
			end
		end
	end
endmodule

>>> sim/tb_chained_hash_table_top.sv
`timescale 1ns / 1ps

module tb_chained_hash_table_top;
	import cht_pkg::*;

	class table_scoreboard;
		logic [KEY_W-1:0] nkey [NODES];
		logic [VAL_W-1:0] nval [NODES];
		link_t nnext [NODES];
		link_t head [BUCKETS];
		logic [NW-1:0] free_stk [NODES];
		int free_cnt;
		logic [CFG_W-1:0] nbuckets;
		logic [1:0] exp_status [$];
		logic [VAL_W-1:0] exp_value [$];
		int errors;
		int checked;

		function new();
			for (int i = 0; i < BUCKETS; i++) head[i] = NULL_LINK;
			for (int i = 0; i < NODES; i++) begin
				nnext[i] = NULL_LINK;
				free_stk[i] = NW'(NODES - 1 - i);
			end
			free_cnt = NODES;
			nbuckets = CFG_W'(DEFAULT_BUCKETS);
			errors = 0;
			checked = 0;
		endfunction

		function int modulus();
			int n;
			n = nbuckets;
			if (n == 0) n = DEFAULT_BUCKETS;
			if (n > BUCKETS) n = BUCKETS;
			return n;
		endfunction

		function void note_request(op_t o, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
			int b;
			int cur;
			int prv;
			int hit;
			int steps;
			int n;
			logic [1:0] st;
			logic [VAL_W-1:0] fv;
			b = k % modulus();
			cur = head[b];
			prv = NODES;
			hit = NODES;
			st = ST_NOT_FOUND;
			fv = '0;
			for (steps = 0; steps < NODES && cur < NODES; steps++) begin
				if (nkey[cur] == k) begin
					hit = cur;
					break;
				end
				prv = cur;
				cur = nnext[cur];
			end
			if (hit == NODES) prv = NODES;
			case (o)
				OP_FIND: if (hit < NODES) begin
					st = ST_OK;
					fv = nval[hit];
				end
				OP_INSERT: begin
					if (hit < NODES) st = ST_EXISTS;
					else if (free_cnt == 0) st = ST_FULL;
					else begin
						free_cnt--;
						n = free_stk[free_cnt];
						nkey[n] = k;
						nval[n] = v;
						nnext[n] = head[b];
						head[b] = link_t'(n);
						st = ST_OK;
					end
				end
				OP_DELETE: if (hit < NODES) begin
					if (prv < NODES) nnext[prv] = nnext[hit];
					else head[b] = nnext[hit];
					nnext[hit] = NULL_LINK;
					if (free_cnt < NODES) begin
						free_stk[free_cnt] = NW'(hit);
						free_cnt++;
					end
					st = ST_OK;
				end
				default: ;
			endcase
			exp_status.push_back(st);
			exp_value.push_back(fv);
		endfunction

		function void check_result(logic [1:0] st, logic [VAL_W-1:0] fv);
			logic [1:0] es;
			logic [VAL_W-1:0] ev;
			checked++;
			if (exp_status.size() == 0) begin
				$display("%0t: unexpected result status=%0d value=%h", $time, st, fv);
				errors++;
				return;
			end
			es = exp_status.pop_front();
			ev = exp_value.pop_front();
			if (st !== es) begin
				$display("%0t: status expected %0d actual %0d", $time, es, st);
				errors++;
			end
			if (fv !== ev) begin
				$display("%0t: found_value expected %h actual %h", $time, ev, fv);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] op;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;
	logic done;
	logic [1:0] status;
	logic [VAL_W-1:0] found_value;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	table_scoreboard sb;
	int cycles;
	localparam int CYCLE_LIMIT = 1500000;

	chained_hash_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .key(key),
		.value(value), .done(done), .status(status), .found_value(found_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (done && sb != null) sb.check_result(status, found_value);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("chained_hash_table_top: mismatch");
			$finish;
		end
	end

	// start stays high after acceptance until the next gap or a drain
	task automatic send_request(op_t o, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		key <= k;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(o, k, v);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (sb.exp_status.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_buckets(logic [CFG_W-1:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.nbuckets = d;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int span);
		if ($urandom_range(0, 19) == 0) return KEY_W'($urandom);
		return KEY_W'($urandom_range(0, span));
	endfunction

	task automatic random_phase(int count, int span);
		int r;
		op_t o;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) o = OP_INSERT;
			else if (r < 65) o = OP_FIND;
			else if (r < 95) o = OP_DELETE;
			else o = OP_NONE;
			send_request(o, pick_key(span), $urandom);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] settings [7];
		sb = new();
		cycles = 0;
		start = 0;
		op = OP_FIND;
		key = '0;
		value = '0;
		cfg_valid = 0;
		cfg_data = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_FIND, '0, '0);
		send_request(OP_INSERT, '0, '1);
		send_request(OP_INSERT, '0, 32'h1234);
		send_request(OP_FIND, '0, '0);
		send_request(OP_INSERT, '1, 32'h0);
		send_request(OP_INSERT, 31'd4, 32'hA5A5A5A5);
		send_request(OP_INSERT, 31'd8, 32'h5A5A5A5A);
		send_request(OP_FIND, 31'd4, '0);
		send_request(OP_DELETE, 31'd4, '0);
		send_request(OP_FIND, 31'd4, '0);
		send_request(OP_DELETE, 31'd4, '0);
		send_request(OP_NONE, '1, '1);
		send_request(OP_FIND, '1, '0);
		send_request(OP_DELETE, '1, '0);
		write_buckets(CFG_W'(0));
		send_request(OP_FIND, 31'd8, '0);
		write_buckets(CFG_W'(63));
		send_request(OP_FIND, 31'd8, '0);
		send_request(OP_INSERT, 31'd40, 32'hFFFF0000);
		write_buckets(CFG_W'(1));
		send_request(OP_FIND, 31'd40, '0);
		for (int i = 0; i < 66; i++) send_request(OP_INSERT, KEY_W'(1000 + i), $urandom);
		send_request(OP_INSERT, 31'd1000, '0);
		for (int i = 0; i < 66; i++) send_request(OP_DELETE, KEY_W'(1000 + i), '0);

		settings = '{6'd4, 6'd32, 6'd1, 6'd7, 6'd0, 6'd45, 6'd13};
		for (int p = 0; p < 7; p++) begin
			write_buckets(settings[p]);
			random_phase(150, (p % 2) ? 200 : 60);
			for (int i = 0; i < 68; i++) send_request(OP_DELETE, KEY_W'(i), '0);
		end
		write_buckets(CFG_W'(32));
		random_phase(120, 50000);

		drain();
		$display("ran %0d results over bucket counts 0,1,4,7,13,32,45,63 incl. full pool",
			sb.checked);
		if (sb.errors == 0 && sb.exp_status.size() == 0)
			$display("chained_hash_table_top: match");
		else
			$display("chained_hash_table_top: mismatch");
		$finish;
	end
endmodule

>>> sim.f
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_mod.sv
rtl/chained_hash_table_top.sv
sim/tb_chained_hash_table_top.sv
